FILE: rtl/client_table_aging_dedup_macros.svh
// ---------------------------------------------------------------------------
// client_table_aging_dedup_macros.svh
// Assertion helpers shared by the client table checkers.
// ---------------------------------------------------------------------------
`ifndef CLIENT_TABLE_AGING_DEDUP_MACROS_SVH
`define CLIENT_TABLE_AGING_DEDUP_MACROS_SVH

// Checked out of reset only.
`define CTAD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define CTAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/ctad_pkg.sv
// ---------------------------------------------------------------------------
// ctad_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package ctad_pkg;

  localparam int unsigned MaxClients = 16;

  localparam int unsigned MacW      = 48;
  localparam int unsigned IdW       = 64;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned LiveTimeW = 16;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned SlotW     = 4;

  localparam int unsigned InDataW  = MacW + IdW + IdW + TimeW;  // 208, whole bytes
  localparam int unsigned OutDataW = 8;
  localparam int unsigned EntryW   = MacW + IdW + IdW + TimeW;

  localparam logic [LiveTimeW-1:0] LiveTimeRst = 16'd60;

  localparam logic [VerdictW-1:0] VerdictNew     = 2'd0;
  localparam logic [VerdictW-1:0] VerdictUpdated = 2'd1;
  localparam logic [VerdictW-1:0] VerdictDup     = 2'd2;
  localparam logic [VerdictW-1:0] VerdictFull    = 2'd3;

  typedef struct packed {
    logic load;  // capture input item, restart scan
    logic rd;    // issue table read at scan index
    logic chk;   // evaluate returned entry
    logic fin;   // commit table write, load result
  } cmd_t;

  typedef struct packed {
    logic last;      // scan index at final entry
    logic out_free;  // result register can take a new result
  } sts_t;

endpackage

FILE: rtl/ctad_ram.sv
// ---------------------------------------------------------------------------
// ctad_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ctad_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ctad_ctrl.sv
// ---------------------------------------------------------------------------
// ctad_ctrl
// Sequencer: accept item, scan table entry by entry, commit and report.
// ---------------------------------------------------------------------------
module ctad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ctad_pkg::sts_t sts_i,
  output ctad_pkg::cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRd   = 2'd1;
  localparam logic [1:0] StChk  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRd;
        end
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d  = StChk;
      end
      StChk: begin
        cmd_o.chk = 1'b1;
        state_d   = sts_i.last ? StDone : StRd;
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign in_ready_o = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/ctad_dp.sv
// ---------------------------------------------------------------------------
// ctad_dp
// Table storage, aging/lookup evaluation, result register.
// ---------------------------------------------------------------------------
module ctad_dp #(
  parameter int unsigned MaxClients = ctad_pkg::MaxClients
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ctad_pkg::cmd_t                     cmd_i,
  output ctad_pkg::sts_t                     sts_o,
  input  logic [ctad_pkg::InDataW-1:0]       in_data_i,
  input  logic                               cfg_valid_i,
  input  logic [ctad_pkg::LiveTimeW-1:0]     cfg_data_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [ctad_pkg::OutDataW-1:0]      out_data_o
);

  localparam int unsigned IdxW = (MaxClients > 1) ? $clog2(MaxClients) : 1;
  localparam int unsigned MacW = ctad_pkg::MacW;
  localparam int unsigned IdW  = ctad_pkg::IdW;
  localparam int unsigned TmW  = ctad_pkg::TimeW;

  // live time register
  logic [ctad_pkg::LiveTimeW-1:0] live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= ctad_pkg::LiveTimeRst;
    end else if (cfg_valid_i) begin
      live_q <= cfg_data_i;
    end
  end

  // captured item
  logic [MacW-1:0] mac_q;
  logic [IdW-1:0]  idh_q, idl_q;
  logic [TmW-1:0]  now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mac_q <= in_data_i[MacW-1:0];
      idh_q <= in_data_i[MacW+IdW-1:MacW];
      idl_q <= in_data_i[MacW+2*IdW-1:MacW+IdW];
      now_q <= in_data_i[MacW+2*IdW+TmW-1:MacW+2*IdW];
    end
  end

  // scan index
  logic [IdxW-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.chk) begin
      idx_q <= idx_q + IdxW'(1);
    end
  end

  assign sts_o.last = (idx_q == IdxW'(MaxClients - 1));

  // table memory: {last_active, id_low, id_high, mac}
  logic [ctad_pkg::EntryW-1:0] rdata;
  logic [MacW-1:0]             e_mac;
  logic [IdW-1:0]              e_idh, e_idl;
  logic [TmW-1:0]              e_last;
  logic                        do_wr;
  logic [IdxW-1:0]             waddr;

  ctad_ram #(
    .Width (ctad_pkg::EntryW),
    .Depth (MaxClients),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i (waddr),
    .wdata_i ({now_q, idl_q, idh_q, mac_q}),
    .re_i    (cmd_i.rd),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign e_mac  = rdata[MacW-1:0];
  assign e_idh  = rdata[MacW+IdW-1:MacW];
  assign e_idl  = rdata[MacW+2*IdW-1:MacW+IdW];
  assign e_last = rdata[MacW+2*IdW+TmW-1:MacW+2*IdW];

  // per-entry evaluation
  logic [TmW-1:0] age;
  logic           expired, alive, mac_hit, id_hit;
  logic [MaxClients-1:0] valid_q, valid_d;

  assign age     = now_q - e_last;
  assign expired = (age > TmW'(live_q));
  assign alive   = valid_q[idx_q] & ~expired;
  assign mac_hit = (e_mac == mac_q);
  assign id_hit  = (e_idh == idh_q) && (e_idl == idl_q);

  logic            found_q, dup_q, have_free_q;
  logic [IdxW-1:0] hit_q, free_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
    end else if (cmd_i.chk) begin
      if (alive) begin
        if (!found_q && mac_hit) begin
          found_q <= 1'b1;
          hit_q   <= idx_q;
          dup_q   <= id_hit;
        end
      end else if (!have_free_q) begin
        have_free_q <= 1'b1;
        free_q      <= idx_q;
      end
    end
  end

  // commit
  logic [ctad_pkg::VerdictW-1:0] verdict;
  logic [ctad_pkg::SlotW-1:0]    slot;

  always_comb begin
    do_wr   = 1'b0;
    waddr   = free_q;
    verdict = ctad_pkg::VerdictFull;
    slot    = '0;
    priority if (found_q) begin
      waddr   = hit_q;
      slot    = ctad_pkg::SlotW'(hit_q);
      verdict = dup_q ? ctad_pkg::VerdictDup : ctad_pkg::VerdictUpdated;
      do_wr   = cmd_i.fin & ~dup_q;
    end else if (have_free_q) begin
      slot    = ctad_pkg::SlotW'(free_q);
      verdict = ctad_pkg::VerdictNew;
      do_wr   = cmd_i.fin;
    end else begin
      do_wr   = 1'b0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.chk && valid_q[idx_q] && expired) begin
      valid_d[idx_q] = 1'b0;
    end
    if (do_wr && !found_q) begin
      valid_d[free_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result register
  logic                          out_valid_q;
  logic [ctad_pkg::VerdictW-1:0] verdict_q;
  logic [ctad_pkg::SlotW-1:0]    slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      verdict_q <= verdict;
      slot_q    <= slot;
    end
  end

  assign sts_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = {2'b00, slot_q, verdict_q};

endmodule

FILE: rtl/client_table_aging_dedup.sv
// ---------------------------------------------------------------------------
// client_table_aging_dedup
// Client table with per-frame aging, learning and duplicate detection.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame descriptor per transfer (MAC, 128-bit request
//   id, current seconds). m_axis returns one verdict per descriptor:
//   new client, updated, duplicate, or table full. cfg_* writes live_time;
//   only write it while no descriptor is in flight.
// Sequence:
//   After an input transfer the table is walked one entry at a time, each
//   entry as a memory read, then age check plus MAC/id compare; the walk is
//   serial, set by the single read port of the entry memory. After the last
//   entry the verdict is loaded into the result register, and only then is
//   the next descriptor accepted.
// Stall:
//   The result sits in an output register; the next descriptor is accepted
//   and scanned while it waits. A scan that finishes before the receiver
//   takes the earlier result holds until the register frees up.
// Reset:
//   Clears all valid bits, live_time goes to 60, no result pending. Entry
//   contents are not cleared; an invalid entry is read but never matches.
// ---------------------------------------------------------------------------
module client_table_aging_dedup #(
  parameter int unsigned MAX_CLIENTS = ctad_pkg::MaxClients
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // source_mac[47:0], request_id_high[111:48], request_id_low[175:112],
  // now_seconds[207:176]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ctad_pkg::InDataW-1:0]       s_axis_tdata,
  // verdict[1:0], slot[5:2], zero pad[7:6]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ctad_pkg::OutDataW-1:0]      m_axis_tdata,
  // live_time write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ctad_pkg::LiveTimeW-1:0]     cfg_data_i
);

  ctad_pkg::cmd_t cmd;
  ctad_pkg::sts_t sts;

  // config is always taken; the register sits in the datapath
  assign cfg_ready_o = 1'b1;

  ctad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ctad_dp #(
    .MaxClients (MAX_CLIENTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/ctad_checker.sv
// ---------------------------------------------------------------------------
// ctad_checker
// Port-level checks for the client table, bound to the top level.
// ---------------------------------------------------------------------------
`include "client_table_aging_dedup_macros.svh"

module ctad_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ctad_pkg::OutDataW-1:0]  m_axis_tdata
);

  `CTAD_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "result during reset")

  `CTAD_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

  `CTAD_ASSERT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while scanning")

  `CTAD_ASSERT(a_full_slot_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1:0] == ctad_pkg::VerdictFull |-> m_axis_tdata[7:2] == 6'd0, "full verdict with slot or pad set")

endmodule

bind client_table_aging_dedup ctad_checker u_ctad_checker (.*);
